// ===== rtl/hrpd_pkg.sv =====
// ----------------------------------------------------------------------------
// hrpd_pkg
// Shared constants and types for the HSV/RGB to PWM duty converter: field
// widths, fixed-point reciprocals for the constant divisors and stage types.
// ----------------------------------------------------------------------------
package hrpd_pkg;

  // Output duty word width and full-scale value.
  localparam int DUTY_BITS = 13;
  localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};

  // Field widths.
  localparam int LVL_W  = 8;
  localparam int HUE_W  = 16;
  localparam int PCT_W  = 7;
  localparam int PROD_W = LVL_W + DUTY_BITS;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // Reciprocals for division by constants. Each is exact over the operand
  // range in which it is used (error term stays below the smallest gap to
  // the next integer).
  localparam logic [15:0] RECIP_360 = 16'd46603;     // 2^24 / 360, floor or one low
  localparam logic [15:0] RECIP_100 = 16'd41944;     // 2^22 / 100, x <= 25500
  localparam logic [14:0] RECIP_60  = 15'd17477;     // 2^20 / 60,  x <= 15045
  localparam logic [24:0] RECIP_255 = 25'd16843010;  // 2^32 / 255, x < 2^24
  localparam int RECIP_255_SHIFT = 32;

  // Pipeline depth, input register through output register.
  localparam int NSTG = 10;

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam logic REG_ACTIVE_HIGH = 1'b0;  // word index of active_high

  // Request kinds.
  localparam logic ACT_HSV = 1'b0;
  localparam logic ACT_RGB = 1'b1;

  // Sixty-degree hue sectors.
  typedef enum logic [2:0] {
    SEC_RED_YEL,
    SEC_YEL_GRN,
    SEC_GRN_CYN,
    SEC_CYN_BLU,
    SEC_BLU_MAG,
    SEC_MAG_RED
  } sector_t;

  // Direct level request that rides along the HSV stages.
  typedef struct packed {
    logic             action;
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] blue;
  } rgb_req_t;

  // Load enables for the two duty scaling stages of one lane.
  typedef struct packed {
    logic en_mul;
    logic en_out;
  } lane_ctl_t;

endpackage

// ===== rtl/hsv_to_rgb_pwm_duty.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_pwm_duty
// Converts one color request (HSV or direct RGB levels) into three PWM duty
// words for an RGB LED.
// ----------------------------------------------------------------------------
// Usage:
//   An item enters on the in_valid/in_ready channel. With action low the
//   hue, saturation and value fields are converted; with action high the
//   three 8-bit levels are used as given. Each item yields exactly one result
//   item of three duty words on the out_valid/out_ready channel.
//   Hue is taken modulo 360; saturation and value above 100 clip to 100.
//   The active_high register (APB word 0) selects direct or inverted duty;
//   the user writes it only while the block is idle; the block does not enforce this.
// Timing:
//   Ten register stages: a result item is offered once its item has passed
//   through all of them, and while out_ready is high one item can be
//   accepted in every cycle. The depth is set by the chain of
//   constant-reciprocal multiplies (hue modulo, peak, floor, sector, ramp
//   and duty scaling).
// Reset and stall:
//   Reset clears all stage valid bits and sets active_high to 0. When the
//   receiver holds out_ready low, each stage keeps its item and only stages
//   behind an empty slot move, so bubbles are squeezed out and in_ready
//   drops only once every stage is full. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pwm_duty (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hrpd_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // Request channel.
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           action,
  input  logic [hrpd_pkg::HUE_W-1:0]     hue_deg,
  input  logic [hrpd_pkg::PCT_W-1:0]     sat_pct,
  input  logic [hrpd_pkg::PCT_W-1:0]     val_pct,
  input  logic [hrpd_pkg::LVL_W-1:0]     red_level,
  input  logic [hrpd_pkg::LVL_W-1:0]     green_level,
  input  logic [hrpd_pkg::LVL_W-1:0]     blue_level,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hrpd_pkg::DUTY_BITS-1:0] red_duty,
  output logic [hrpd_pkg::DUTY_BITS-1:0] green_duty,
  output logic [hrpd_pkg::DUTY_BITS-1:0] blue_duty
);

  localparam int NSTG = hrpd_pkg::NSTG;
  localparam int LW   = hrpd_pkg::LVL_W;
  localparam int PW   = hrpd_pkg::PCT_W;

  // --------------------------------------------------------------------------
  // Configuration register.
  // --------------------------------------------------------------------------
  logic active_high;
  logic cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == hrpd_pkg::REG_ACTIVE_HIGH);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_high <= 1'b0;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      active_high <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_hit) begin
      prdata[0] = active_high;
    end
  end

  // --------------------------------------------------------------------------
  // Stage flow control. A stage loads when it is empty or when the stage
  // after it moves on, so bubbles collapse under a stall.
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: clip percentages, estimate hue / 360, form value * 255.
  // --------------------------------------------------------------------------
  hrpd_pkg::rgb_req_t req1, req2, req3, req4, req5, req6, req7;
  logic [hrpd_pkg::HUE_W-1:0] hue1;
  logic [7:0]                 hq1;
  logic [PW-1:0]              sat1, sat2;
  logic [14:0]                pk_prod1;

  logic [PW-1:0] sat_c, val_c;
  logic [31:0]   hq_full;

  assign sat_c   = (sat_pct > hrpd_pkg::PCT_MAX) ? hrpd_pkg::PCT_MAX : sat_pct;
  assign val_c   = (val_pct > hrpd_pkg::PCT_MAX) ? hrpd_pkg::PCT_MAX : val_pct;
  assign hq_full = 32'(hue_deg) * 32'(hrpd_pkg::RECIP_360);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      req1     <= '{action: action, red: red_level, green: green_level,
                    blue: blue_level};
      hue1     <= hue_deg;
      hq1      <= hq_full[31:24];
      sat1     <= sat_c;
      pk_prod1 <= 15'(val_c) * 15'd255;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: partial hue remainder (below 720) and peak level.
  // --------------------------------------------------------------------------
  logic [9:0]    h2;
  logic [LW-1:0] peak2, peak3, peak4, peak5, peak6, peak7;
  logic [16:0]   hq_x360;
  logic [30:0]   peak_full;

  assign hq_x360   = 17'(hq1) * 17'd360;
  assign peak_full = 31'(pk_prod1) * 31'(hrpd_pkg::RECIP_100);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      req2  <= req1;
      h2    <= 10'({1'b0, hue1} - hq_x360);
      peak2 <= peak_full[29:22];
      sat2  <= sat1;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: final hue correction and peak * (100 - sat).
  // --------------------------------------------------------------------------
  logic [8:0]  hm3, hm4;
  logic [14:0] base_prod3;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      req3       <= req2;
      hm3        <= (h2 >= 10'd360) ? 9'(h2 - 10'd360) : h2[8:0];
      peak3      <= peak2;
      base_prod3 <= 15'(peak2) * 15'(hrpd_pkg::PCT_MAX - sat2);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: floor level and sector number.
  // --------------------------------------------------------------------------
  logic [LW-1:0]     base4, base5, base6, base7;
  hrpd_pkg::sector_t sec4, sec5, sec6, sec7;
  logic [30:0]       base_full;
  logic [23:0]       sec_full;

  assign base_full = 31'(base_prod3) * 31'(hrpd_pkg::RECIP_100);
  assign sec_full  = 24'(hm3) * 24'(hrpd_pkg::RECIP_60);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      req4  <= req3;
      hm4   <= hm3;
      peak4 <= peak3;
      base4 <= base_full[29:22];
      sec4  <= hrpd_pkg::sector_t'(sec_full[22:20]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: degrees into the sector and span between peak and floor.
  // --------------------------------------------------------------------------
  logic [5:0]    rem5;
  logic [LW-1:0] diff5;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      req5  <= req4;
      peak5 <= peak4;
      base5 <= base4;
      sec5  <= sec4;
      rem5  <= 6'(hm4 - 9'(sec4) * 9'd60);
      diff5 <= peak4 - base4;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: span * degrees.
  // --------------------------------------------------------------------------
  logic [13:0] ramp_prod6;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      req6       <= req5;
      peak6      <= peak5;
      base6      <= base5;
      sec6       <= sec5;
      ramp_prod6 <= 14'(diff5) * 14'(rem5);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: ramp = span * degrees / 60.
  // --------------------------------------------------------------------------
  logic [LW-1:0] ramp7;
  logic [28:0]   ramp_full;

  assign ramp_full = 29'(ramp_prod6) * 29'(hrpd_pkg::RECIP_60);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      req7  <= req6;
      peak7 <= peak6;
      base7 <= base6;
      sec7  <= sec6;
      ramp7 <= ramp_full[27:20];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: pick the three levels, from the sector or from the request.
  // --------------------------------------------------------------------------
  logic [LW-1:0] red8, green8, blue8;
  logic [LW-1:0] r_sel, g_sel, b_sel;
  logic [LW-1:0] rise, fall;

  assign rise = base7 + ramp7;
  assign fall = peak7 - ramp7;

  always_comb begin
    r_sel = peak7;
    g_sel = base7;
    b_sel = fall;
    if (req7.action == hrpd_pkg::ACT_RGB) begin
      r_sel = req7.red;
      g_sel = req7.green;
      b_sel = req7.blue;
    end else begin
      case (sec7)
        hrpd_pkg::SEC_RED_YEL: begin
          r_sel = peak7; g_sel = rise;  b_sel = base7;
        end
        hrpd_pkg::SEC_YEL_GRN: begin
          r_sel = fall;  g_sel = peak7; b_sel = base7;
        end
        hrpd_pkg::SEC_GRN_CYN: begin
          r_sel = base7; g_sel = peak7; b_sel = rise;
        end
        hrpd_pkg::SEC_CYN_BLU: begin
          r_sel = base7; g_sel = fall;  b_sel = peak7;
        end
        hrpd_pkg::SEC_BLU_MAG: begin
          r_sel = rise;  g_sel = base7; b_sel = peak7;
        end
        default: begin
          r_sel = peak7; g_sel = base7; b_sel = fall;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      red8   <= r_sel;
      green8 <= g_sel;
      blue8  <= b_sel;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 9 and 10: duty scaling and polarity, one lane per color.
  // --------------------------------------------------------------------------
  hrpd_pkg::lane_ctl_t lane_ctl;

  assign lane_ctl = '{en_mul: adv[8], en_out: adv[9]};

  hrpd_duty_lane u_red (
    .clk         (clk),
    .ctl         (lane_ctl),
    .active_high (active_high),
    .level       (red8),
    .duty        (red_duty)
  );

  hrpd_duty_lane u_green (
    .clk         (clk),
    .ctl         (lane_ctl),
    .active_high (active_high),
    .level       (green8),
    .duty        (green_duty)
  );

  hrpd_duty_lane u_blue (
    .clk         (clk),
    .ctl         (lane_ctl),
    .active_high (active_high),
    .level       (blue8),
    .duty        (blue_duty)
  );

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // With the output slot empty every stage can move, so a request is taken.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low while the output stage is empty");

  // Hue correction leaves a remainder below one full turn.
  a_hue_in_turn: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> (hm3 < 9'd360))
    else $error("reduced hue out of range");

  // The floor level never exceeds the peak level.
  a_floor_below_peak: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (base4 <= peak4))
    else $error("floor level above peak level");

  // Sector offset stays inside one sixty-degree sector.
  a_sector_offset: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (rem5 < 6'd60))
    else $error("sector offset out of range");

  // The ramp never overshoots the span between floor and peak.
  a_ramp_in_span: assert property (@(posedge clk) disable iff (rst)
    vld[6] |-> (ramp7 <= (peak7 - base7)))
    else $error("ramp exceeds span");

endmodule

// ===== rtl/hrpd_duty_lane.sv =====
// ----------------------------------------------------------------------------
// hrpd_duty_lane
// Two-stage scaling of one 8-bit level to a PWM duty word:
// duty = level * DUTY_MAX / 255, inverted for an active-low LED.
// ----------------------------------------------------------------------------
module hrpd_duty_lane (
  input  logic                           clk,
  input  hrpd_pkg::lane_ctl_t            ctl,
  input  logic                           active_high,
  input  logic [hrpd_pkg::LVL_W-1:0]     level,
  output logic [hrpd_pkg::DUTY_BITS-1:0] duty
);

  localparam int FULL_W = hrpd_pkg::PROD_W + 25;

  logic [hrpd_pkg::PROD_W-1:0]    prod;
  logic [FULL_W-1:0]              scaled;
  logic [hrpd_pkg::DUTY_BITS-1:0] quot;

  // Division by 255 through a reciprocal multiply.
  assign scaled = FULL_W'(prod) * FULL_W'(hrpd_pkg::RECIP_255);
  assign quot   = scaled[hrpd_pkg::RECIP_255_SHIFT +: hrpd_pkg::DUTY_BITS];

  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      prod <= hrpd_pkg::PROD_W'(level) * hrpd_pkg::PROD_W'(hrpd_pkg::DUTY_MAX);
    end
    if (ctl.en_out) begin
      // DUTY_MAX - d is the bitwise complement within the duty width.
      duty <= active_high ? quot : ~quot;
    end
  end

endmodule
